>>> rtl/core/lfuc_pkg.sv
package lfuc_pkg;

  // Field widths of the request and result channels.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 32;
  localparam int CAP_W = 5;

  // Default number of slots and the capacity after reset.
  localparam int ENTRIES_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Value returned when a request reads nothing.
  localparam logic signed [VAL_W-1:0] RD_MISS = -32'sd1;

  // Use count given to a freshly inserted entry.
  localparam logic [CNT_W-1:0] CNT_FIRST = 32'd1;

endpackage

>>> rtl/core/lfu_cache_lru_tiebreak_unit.sv
// Key-value cache with least-frequently-used replacement; among entries of
// equal use count the least recently used one is evicted first.
//
// A request (get or put, key, value) is accepted at a rising edge where start
// is high and busy is low. The result (hit, read value, evicted flag and key)
// appears on the out_ ports, marked by out_strobe for exactly one cycle. The
// receiver cannot hold a result off, so nothing waits on the output side.
//
// One request at a time. A pass over all ENTRIES slots of the entry
// and rank memories finds the key, the first free slot and the victim; a
// second read-modify-write pass over the rank memory renumbers the ranks. A
// get that misses, or any request at capacity zero, skips the second pass.
// Busy drops with the strobe; no new request is taken before then.
//
// Reset (synchronous, active low) clears all valid bits, the occupancy count
// and the output strobe and sets the capacity to 16; only slots marked valid
// are looked at, so the memories need no clearing pass. The user must write
// the capacity via cfg_we/cfg_wdata only while idle; the block does not check.
module lfu_cache_lru_tiebreak_unit
  import lfuc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_action,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic                    out_evicted,
  output logic [KEY_W-1:0]        out_evicted_key,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_wdata
);

  // Slot index and rank widths; a rank runs from 0 (most recent) upward.
  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW    = IW;
  localparam int OW    = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OW > CAP_W) ? OW : CAP_W;
  localparam logic [IW-1:0]    LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [CMP_W-1:0] ENT_CMP  = CMP_W'(ENTRIES);

  // One entry memory word holds the key, the value and the use count.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  // Sequencer: SCAN issues one slot read a cycle, TAIL takes the last read
  // data, DECIDE commits the entry write, RANK sweeps the rank memory and
  // FINISH retires the last rank write and launches the result strobe.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_TAIL   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_RANK   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic               scan_pend_r, scan_pend_nxt;
  logic               rank_pend_r, rank_pend_nxt;
  logic [IW-1:0]      pend_idx_r, pend_idx_nxt;
  logic               strobe_r, strobe_nxt;

  // Request held for the whole access.
  logic             req_put_r, req_put_nxt;
  logic [KEY_W-1:0] req_key_r, req_key_nxt;
  logic [VAL_W-1:0] req_val_r, req_val_nxt;

  // What the scan pass has found so far.
  logic             mt_found_r, mt_found_nxt;
  logic [IW-1:0]    mt_idx_r, mt_idx_nxt;
  logic [RW-1:0]    mt_rank_r, mt_rank_nxt;
  logic [VAL_W-1:0] mt_value_r, mt_value_nxt;
  logic [CNT_W-1:0] mt_cnt_r, mt_cnt_nxt;
  logic             fr_found_r, fr_found_nxt;
  logic [IW-1:0]    fr_idx_r, fr_idx_nxt;
  logic             vc_found_r, vc_found_nxt;
  logic [IW-1:0]    vc_idx_r, vc_idx_nxt;
  logic [RW-1:0]    vc_rank_r, vc_rank_nxt;
  logic [CNT_W-1:0] vc_cnt_r, vc_cnt_nxt;
  logic [KEY_W-1:0] vc_key_r, vc_key_nxt;

  // How the rank pass renumbers: a touch or an insert, around a target slot.
  logic          rk_ins_r, rk_ins_nxt;
  logic          rk_evict_r, rk_evict_nxt;
  logic [RW-1:0] rk_ref_r, rk_ref_nxt;
  logic [IW-1:0] rk_tgt_r, rk_tgt_nxt;

  // Result registers.
  logic             res_hit_r, res_hit_nxt;
  logic [VAL_W-1:0] res_rd_r, res_rd_nxt;
  logic             res_ev_r, res_ev_nxt;
  logic [KEY_W-1:0] res_evk_r, res_evk_nxt;

  // Memory ports.
  logic          ent_we;
  logic [IW-1:0] ent_waddr;
  entry_t        ent_wdata;
  entry_t        ent_rdata;
  logic [ENT_W-1:0] ent_rdata_raw;
  logic          rank_we;
  logic [RW-1:0] rank_wdata;
  logic [RW-1:0] rank_rdata;

  // Decision helpers for the DECIDE cycle.
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic             do_evict;
  logic             do_insert;
  logic [IW-1:0]    ins_idx;
  logic             scan_valid;

  assign ent_rdata = entry_t'(ent_rdata_raw);

  lfuc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ENT_W'(ent_wdata)),
    .raddr (cnt_r),
    .rdata (ent_rdata_raw)
  );

  // The rank pass reads slot i and writes it back in the cycle after, while
  // reading slot i+1, so a read never meets an outstanding write to its slot.
  lfuc_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (pend_idx_r),
    .wdata (rank_wdata),
    .raddr (cnt_r),
    .rdata (rank_rdata)
  );

  assign busy = (state_r != ST_IDLE);

  // Capacity above the slot count acts as the slot count.
  assign cap_ext   = CMP_W'(cap_r);
  assign cap_eff   = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;
  assign do_evict  = (CMP_W'(occ_r) >= cap_eff) && vc_found_r;
  assign do_insert = do_evict || fr_found_r;
  // The new key takes the lowest free slot once the victim has left.
  assign ins_idx   = (do_evict && !(fr_found_r && (fr_idx_r < vc_idx_r))) ?
                     vc_idx_r : fr_idx_r;
  assign scan_valid = valid_r[pend_idx_r];

  // Renumbered rank of the slot whose read data is at hand.
  always_comb begin
    rank_we    = rank_pend_r;
    rank_wdata = rank_rdata;
    if (pend_idx_r == rk_tgt_r) begin
      rank_wdata = '0;
    end else if (rk_ins_r) begin
      if (rk_evict_r && (rank_rdata > rk_ref_r)) begin
        rank_wdata = rank_rdata;
      end else begin
        rank_wdata = rank_rdata + RW'(1);
      end
    end else if (rank_rdata < rk_ref_r) begin
      rank_wdata = rank_rdata + RW'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    valid_nxt     = valid_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    scan_pend_nxt = 1'b0;
    rank_pend_nxt = 1'b0;
    pend_idx_nxt  = cnt_r;
    strobe_nxt    = 1'b0;

    req_put_nxt  = req_put_r;
    req_key_nxt  = req_key_r;
    req_val_nxt  = req_val_r;
    mt_found_nxt = mt_found_r;
    mt_idx_nxt   = mt_idx_r;
    mt_rank_nxt  = mt_rank_r;
    mt_value_nxt = mt_value_r;
    mt_cnt_nxt   = mt_cnt_r;
    fr_found_nxt = fr_found_r;
    fr_idx_nxt   = fr_idx_r;
    vc_found_nxt = vc_found_r;
    vc_idx_nxt   = vc_idx_r;
    vc_rank_nxt  = vc_rank_r;
    vc_cnt_nxt   = vc_cnt_r;
    vc_key_nxt   = vc_key_r;
    rk_ins_nxt   = rk_ins_r;
    rk_evict_nxt = rk_evict_r;
    rk_ref_nxt   = rk_ref_r;
    rk_tgt_nxt   = rk_tgt_r;
    res_hit_nxt  = res_hit_r;
    res_rd_nxt   = res_rd_r;
    res_ev_nxt   = res_ev_r;
    res_evk_nxt  = res_evk_r;

    ent_we    = 1'b0;
    ent_waddr = mt_idx_r;
    ent_wdata = '{key: req_key_r, value: req_val_r, count: CNT_FIRST};

    if (cfg_we) begin
      cap_nxt = cfg_wdata;
    end

    // Fold in one slot of scan data: key match, first free slot, victim.
    if (scan_pend_r) begin
      if (scan_valid && (ent_rdata.key == req_key_r) && !mt_found_r) begin
        mt_found_nxt = 1'b1;
        mt_idx_nxt   = pend_idx_r;
        mt_rank_nxt  = rank_rdata;
        mt_value_nxt = ent_rdata.value;
        mt_cnt_nxt   = ent_rdata.count;
      end
      if (!scan_valid && !fr_found_r) begin
        fr_found_nxt = 1'b1;
        fr_idx_nxt   = pend_idx_r;
      end
      if (scan_valid && (!vc_found_r || (ent_rdata.count < vc_cnt_r) ||
          ((ent_rdata.count == vc_cnt_r) && (rank_rdata > vc_rank_r)))) begin
        vc_found_nxt = 1'b1;
        vc_idx_nxt   = pend_idx_r;
        vc_rank_nxt  = rank_rdata;
        vc_cnt_nxt   = ent_rdata.count;
        vc_key_nxt   = ent_rdata.key;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt    = ST_SCAN;
          cnt_nxt      = '0;
          req_put_nxt  = (in_action == ACT_PUT);
          req_key_nxt  = in_key;
          req_val_nxt  = in_value;
          mt_found_nxt = 1'b0;
          fr_found_nxt = 1'b0;
          vc_found_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        scan_pend_nxt = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_TAIL;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_TAIL: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_hit_nxt = 1'b0;
        res_rd_nxt  = RD_MISS;
        res_ev_nxt  = 1'b0;
        res_evk_nxt = '0;
        state_nxt   = ST_FINISH;
        if (cap_eff == '0) begin
          // Storing disabled: nothing changes.
        end else if (mt_found_r) begin
          // Hit on get or put: bump the count and make the entry most recent.
          res_hit_nxt = 1'b1;
          if (!req_put_r) begin
            res_rd_nxt = mt_value_r;
          end
          ent_we          = 1'b1;
          ent_waddr       = mt_idx_r;
          ent_wdata.key   = req_key_r;
          ent_wdata.value = req_put_r ? req_val_r : mt_value_r;
          ent_wdata.count = (mt_cnt_r == '1) ? mt_cnt_r : (mt_cnt_r + CNT_W'(1));
          rk_ins_nxt   = 1'b0;
          rk_evict_nxt = 1'b0;
          rk_ref_nxt   = mt_rank_r;
          rk_tgt_nxt   = mt_idx_r;
          state_nxt    = ST_RANK;
        end else if (req_put_r) begin
          if (do_evict) begin
            res_ev_nxt            = 1'b1;
            res_evk_nxt           = vc_key_r;
            valid_nxt[vc_idx_r]   = 1'b0;
          end
          if (do_insert) begin
            valid_nxt[ins_idx] = 1'b1;
            ent_we             = 1'b1;
            ent_waddr          = ins_idx;
            if (!do_evict) begin
              occ_nxt = occ_r + OW'(1);
            end
            rk_ins_nxt   = 1'b1;
            rk_evict_nxt = do_evict;
            rk_ref_nxt   = vc_rank_r;
            rk_tgt_nxt   = ins_idx;
            state_nxt    = ST_RANK;
          end
        end
      end
      ST_RANK: begin
        rank_pend_nxt = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_FINISH: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      scan_pend_r <= 1'b0;
      rank_pend_r <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      scan_pend_r <= scan_pend_nxt;
      rank_pend_r <= rank_pend_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    req_put_r  <= req_put_nxt;
    req_key_r  <= req_key_nxt;
    req_val_r  <= req_val_nxt;
    mt_found_r <= mt_found_nxt;
    mt_idx_r   <= mt_idx_nxt;
    mt_rank_r  <= mt_rank_nxt;
    mt_value_r <= mt_value_nxt;
    mt_cnt_r   <= mt_cnt_nxt;
    fr_found_r <= fr_found_nxt;
    fr_idx_r   <= fr_idx_nxt;
    vc_found_r <= vc_found_nxt;
    vc_idx_r   <= vc_idx_nxt;
    vc_rank_r  <= vc_rank_nxt;
    vc_cnt_r   <= vc_cnt_nxt;
    vc_key_r   <= vc_key_nxt;
    rk_ins_r   <= rk_ins_nxt;
    rk_evict_r <= rk_evict_nxt;
    rk_ref_r   <= rk_ref_nxt;
    rk_tgt_r   <= rk_tgt_nxt;
    res_hit_r  <= res_hit_nxt;
    res_rd_r   <= res_rd_nxt;
    res_ev_r   <= res_ev_nxt;
    res_evk_r  <= res_evk_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_hit         = res_hit_r;
  assign out_read_value  = res_rd_r;
  assign out_evicted     = res_ev_r;
  assign out_evicted_key = res_evk_r;

  // The occupancy count always matches the number of valid slots.
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy count differs from valid slots");

  // No two results can come in back-to-back cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // An eviction only happens on a put that missed.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_evicted) |-> (!out_hit && (out_read_value == RD_MISS)))
    else $error("eviction reported together with a hit or a read value");

endmodule

>>> rtl/core/lfuc_ram.sv
module lfuc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
